FILE: design/pad_strobe_image_loader_core_macros.svh
// assertion macros shared by the pad strobe image loader modules
// no dependencies; taken in by the files that check their own logic
`ifndef PAD_STROBE_IMAGE_LOADER_CORE_MACROS_SVH
`define PAD_STROBE_IMAGE_LOADER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PSIL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psil check failed");

// next-cycle implication, disabled in reset
`define PSIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psil check failed");

`endif

FILE: design/psil_pkg.sv
// types, constants and helper functions of the pad strobe image loader
// no dependencies
`timescale 1ns / 1ps

package psil_pkg;

    localparam int PAD_W        = 16;
    localparam int OFS_W        = 25;
    localparam int SIZE_W       = 24;
    localparam int MODE_W       = 6;
    localparam int ITYPE_W      = 2;
    localparam int LA_W         = 32;
    localparam int R1_BIT       = 3;
    localparam int LEFT_BIT     = 15;
    localparam int HEADER_BYTES = 7;
    // last header byte is used straight from the receiver, never stored
    localparam int HDR_STORE    = HEADER_BYTES - 1;
    localparam int HIDX_W       = $clog2(HEADER_BYTES);
    localparam int SKIP_FROM    = 128;
    localparam int SKIP_TO      = 2048;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [MODE_W-1:0]  WIDE_MODE = 6'd2;
    localparam logic [ITYPE_W-1:0] SKIP_TYPE = 2'd1;
    localparam logic [7:0]         LA_TOP    = 8'h80;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT_HDR,
        PH_HDR,
        PH_WAIT_DATA,
        PH_DATA,
        PH_DONE
    } t_phase;

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic                     kind;
        logic                     triple;
        logic [2:0][7:0]          bytes;
        logic [OFS_W-1:0]         ofs;
        logic                     skip;
        logic                     launch;
        logic [23:0]              la_low;
        logic [SIZE_W-1:0]        size;
        logic [MODE_W-1:0]        mode;
        logic [ITYPE_W-1:0]       img_type;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push_req;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

    typedef struct packed {
        logic                     kind;
        logic [OFS_W-1:0]         offset;
        logic [7:0]               data_byte;
        logic [LA_W-1:0]          load_address;
        logic [SIZE_W-1:0]        image_size;
        logic [MODE_W-1:0]        link_mode;
        logic [ITYPE_W-1:0]       image_type;
        logic                     launch;
        logic                     last;
    } t_result;

    // advance the write offset by step bytes, jumping from 128 to 2048 when skip is set
    function automatic logic [OFS_W-1:0] psil_adv(input logic [OFS_W-1:0] ofs,
                                                  input logic [1:0]       step,
                                                  input logic             skip);
        logic [OFS_W-1:0] sum;
        sum = ofs + OFS_W'(step);
        if (skip && (ofs < OFS_W'(SKIP_FROM)) && (sum >= OFS_W'(SKIP_FROM))) begin
            sum = sum + OFS_W'(SKIP_TO - SKIP_FROM);
        end
        return sum;
    endfunction

endpackage

FILE: design/psil_if.sv
// valid/ready channel interfaces for pad samples and loader results
// depends on psil_pkg
`timescale 1ns / 1ps

interface psil_in_if import psil_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PAD_W-1:0] pad_state;

    modport source (output valid, output pad_state, input ready);
    modport sink   (input valid, input pad_state, output ready);
endinterface

interface psil_out_if import psil_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [OFS_W-1:0]    offset;
    logic [7:0]          data_byte;
    logic [LA_W-1:0]     load_address;
    logic [SIZE_W-1:0]   image_size;
    logic [MODE_W-1:0]   link_mode;
    logic [ITYPE_W-1:0]  image_type;
    logic                launch;
    logic                last;

    modport source (output valid, output kind, output offset, output data_byte,
                    output load_address, output image_size, output link_mode,
                    output image_type, output launch, output last, input ready);
    modport sink   (input valid, input kind, input offset, input data_byte,
                    input load_address, input image_size, input link_mode,
                    input image_type, input launch, input last, output ready);
endinterface

FILE: design/pad_strobe_image_loader_core.sv
// pad strobe image loader, top level: front end, job queue and back end
// a sample's first result passes the queue, the back-end job register and the output register
// a sample is accepted every cycle while the job queue has room; results leave one per cycle
// while o_res is ready; a 14-button sample's three writes hold the back end until all are out
// reset: synchronous active-low i_rst_n clears phase, receiver, counters and queue;
// header bytes and payload registers are not reset
`timescale 1ns / 1ps

module pad_strobe_image_loader_core import psil_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psil_in_if.sink    i_pad,
    psil_out_if.source o_res
);

    // job handoff from the front end into the queue
    t_push_req  push_req;
    // queue full back-pressures the pad channel directly
    logic       q_full;
    // head of the queue, consumed by the back end
    t_q_head    q_head;
    logic       q_pop;

    // front end: waits for R1 release, receives bytes on strobe rising edges,
    // decodes the header once, then tracks the write offset and the launch test
    psil_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pad    (i_pad),
        .i_q_full (q_full),
        .o_push   (push_req)
    );

    // decouples sample intake from result delivery so either side can stall
    psil_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_req),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // back end: turns each job into one header report or one/three byte writes,
    // one result transaction per cycle while o_res is ready, via a registered output stage
    psil_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

FILE: design/psil_front.sv
// front end: phase sequencing, strobe edge receiver, header decode, offset and launch
// depends on psil_pkg and psil_in_if
`timescale 1ns / 1ps

module psil_front import psil_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psil_in_if.sink      i_pad,
    input  logic         i_q_full,
    output t_push_req    o_push
);

    t_phase                 r_phase, n_phase;
    logic                   r_prev, n_prev;
    logic [1:0]             r_ec, n_ec;
    logic [2:0][7:0]        r_acc, n_acc;
    logic [7:0]             r_hdr [HDR_STORE];
    logic [HIDX_W-1:0]      r_hidx, n_hidx;
    logic [SIZE_W-1:0]      r_size, n_size;
    logic [MODE_W-1:0]      r_mode, n_mode;
    logic [ITYPE_W-1:0]     r_type, n_type;
    logic [OFS_W-1:0]       r_ofs, n_ofs;

    logic                   fire;
    logic [PAD_W-1:0]       pad;
    logic                   wide;
    logic                   strobe;
    logic                   rise;
    logic                   byte_done;
    logic                   hdr_we;
    logic                   hdr_done;
    logic                   launch_now;
    logic [OFS_W-1:0]       ofs_adv;

    assign i_pad.ready = !i_q_full;
    assign fire        = i_pad.valid && i_pad.ready;
    assign pad         = i_pad.pad_state;
    assign wide        = (r_phase == PH_DATA) && (r_mode == WIDE_MODE);
    assign strobe      = wide ? pad[LEFT_BIT] : pad[R1_BIT];
    assign rise        = strobe && (strobe != r_prev);
    assign ofs_adv     = psil_adv(r_ofs, wide ? 2'd3 : 2'd1, r_type == SKIP_TYPE);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_WAIT_HDR: begin
                if (fire && !pad[R1_BIT]) n_phase = PH_HDR;
            end
            PH_HDR: begin
                if (hdr_done) n_phase = PH_WAIT_DATA;
            end
            PH_WAIT_DATA: begin
                if (fire && !pad[R1_BIT]) n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (launch_now) n_phase = PH_DONE;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_WAIT_HDR;
            end
        endcase
    end

    // receiver, header decode and job build
    always_comb begin
        n_prev     = r_prev;
        n_ec       = r_ec;
        n_acc      = r_acc;
        n_hidx     = r_hidx;
        n_size     = r_size;
        n_mode     = r_mode;
        n_type     = r_type;
        n_ofs      = r_ofs;
        byte_done  = 1'b0;
        hdr_we     = 1'b0;
        hdr_done   = 1'b0;
        launch_now = 1'b0;
        o_push     = '0;

        if (fire && ((r_phase == PH_HDR) || (r_phase == PH_DATA))) begin
            if (strobe != r_prev) n_prev = strobe;
            if (rise) begin
                n_ec = 2'(r_ec + 2'd1);
                if (wide) begin
                    case (r_ec)
                        2'd0: begin
                            n_acc[0] = pad[7:0];
                            n_acc[1] = {4'b0000, pad[13:10] | {3'b000, pad[8]}};
                        end
                        2'd1: begin
                            n_acc[2] = pad[7:0];
                            n_acc[1] = r_acc[1] | {pad[13:10] | {3'b000, pad[8]}, 4'b0000};
                        end
                        default: begin
                        end
                    endcase
                    byte_done = (r_ec != 2'd0);
                end else begin
                    case (r_ec)
                        2'd0: n_acc[0] = {5'b00000, pad[2:0]};
                        2'd1: n_acc[0] = r_acc[0] | {2'b00, pad[2:0], 3'b000};
                        2'd2: n_acc[0] = r_acc[0] | {pad[1:0], 6'b000000};
                        default: begin
                        end
                    endcase
                    byte_done = (r_ec >= 2'd2);
                end
                if (byte_done) n_ec = 2'd0;
            end
        end

        if (byte_done && (r_phase == PH_HDR)) begin
            if (r_hidx == HIDX_W'(HDR_STORE)) begin
                hdr_done             = 1'b1;
                n_hidx               = '0;
                n_size               = {r_hdr[2], r_hdr[1], r_hdr[0]};
                n_mode               = r_hdr[3][MODE_W-1:0];
                n_type               = r_hdr[3][7:6];
                o_push.push          = 1'b1;
                o_push.job.kind      = KIND_HEADER;
                o_push.job.la_low    = {n_acc[0], r_hdr[5], r_hdr[4]};
                o_push.job.size      = {r_hdr[2], r_hdr[1], r_hdr[0]};
                o_push.job.mode      = r_hdr[3][MODE_W-1:0];
                o_push.job.img_type  = r_hdr[3][7:6];
            end else begin
                hdr_we = 1'b1;
                n_hidx = HIDX_W'(r_hidx + 1'b1);
            end
        end

        if (byte_done && (r_phase == PH_DATA)) begin
            n_ofs              = ofs_adv;
            launch_now         = (r_size != '0) && (ofs_adv != '0) &&
                                 (ofs_adv >= {1'b0, r_size});
            o_push.push        = 1'b1;
            o_push.job.kind    = KIND_DATA;
            o_push.job.triple  = wide;
            o_push.job.bytes   = n_acc;
            o_push.job.ofs     = r_ofs;
            o_push.job.skip    = (r_type == SKIP_TYPE);
            o_push.job.launch  = launch_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_HDR;
            r_prev  <= 1'b0;
            r_ec    <= '0;
            r_acc   <= '0;
            r_hidx  <= '0;
            r_size  <= '0;
            r_mode  <= '0;
            r_type  <= '0;
            r_ofs   <= '0;
        end else begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_ec    <= n_ec;
            r_acc   <= n_acc;
            r_hidx  <= n_hidx;
            r_size  <= n_size;
            r_mode  <= n_mode;
            r_type  <= n_type;
            r_ofs   <= n_ofs;
        end
    end

    // header bytes, no reset: each is written before it is read
    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_hidx] <= n_acc[0];
        end
    end

endmodule

FILE: design/psil_queue.sv
// short job queue between the front and the back
// depends on psil_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "pad_strobe_image_loader_core_macros.svh"

module psil_queue import psil_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push_req  i_push,
    input  logic       i_pop,
    output logic       o_full,
    output t_q_head    o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    `PSIL_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `PSIL_ASSERT_NOW(a_no_drop, i_clk, i_rst_n, i_push.push, !o_full)
    `PSIL_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

FILE: design/psil_back.sv
// back end: expands jobs into result transactions through a registered output
// depends on psil_pkg, psil_out_if and the assertion macro header
`timescale 1ns / 1ps
`include "pad_strobe_image_loader_core_macros.svh"

module psil_back import psil_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_head    i_head,
    output logic       o_pop,
    psil_out_if.source o_res
);

    logic              r_busy, n_busy;
    t_job              r_job, n_job;
    logic [1:0]        r_idx, n_idx;
    logic [OFS_W-1:0]  r_cur, n_cur;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              load_out;
    logic              item_last;

    assign load_out  = r_busy && (!r_out_valid || o_res.ready);
    assign item_last = !r_job.triple || (r_idx == 2'd2);
    assign o_pop     = i_head.valid && (!r_busy || (load_out && item_last));

    always_comb begin
        n_busy      = r_busy;
        n_job       = r_job;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (load_out) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.kind  = r_job.kind;
            n_out.last  = item_last;
            if (r_job.kind == KIND_HEADER) begin
                n_out.load_address = {LA_TOP, r_job.la_low};
                n_out.image_size   = r_job.size;
                n_out.link_mode    = r_job.mode;
                n_out.image_type   = r_job.img_type;
            end else begin
                n_out.offset    = r_cur;
                n_out.data_byte = r_job.bytes[r_idx];
                n_out.launch    = r_job.launch && item_last;
            end
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_head.job;
            n_idx  = '0;
            n_cur  = i_head.job.ofs;
        end else if (load_out && item_last) begin
            n_busy = 1'b0;
        end else if (load_out) begin
            n_idx = 2'(r_idx + 2'd1);
            n_cur = psil_adv(r_cur, 2'd1, r_job.skip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.offset       = r_out.offset;
    assign o_res.data_byte    = r_out.data_byte;
    assign o_res.load_address = r_out.load_address;
    assign o_res.image_size   = r_out.image_size;
    assign o_res.link_mode    = r_out.link_mode;
    assign o_res.image_type   = r_out.image_type;
    assign o_res.launch       = r_out.launch;
    assign o_res.last         = r_out.last;

    `PSIL_ASSERT_NOW(a_launch_is_last, i_clk, i_rst_n, r_out_valid && r_out.launch, r_out.last)
    `PSIL_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, r_busy, r_idx != 2'd3)
    `PSIL_ASSERT_NEXT(a_triple_continues, i_clk, i_rst_n, load_out && !item_last, r_busy)

endmodule
